@@ rtl/core/mec_pkg.sv @@
`default_nettype none

package mec_pkg;

  // fixed-point formats
  localparam int FRAC_BITS_DEF = 28;
  localparam int IN_FRAC       = 28;
  localparam int POINT_W       = 32;

  // iteration limit register
  localparam int                LIMIT_W        = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX      = 12'd4094;
  localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = 12'hfff;

  // palette
  localparam int COLOR_W   = 24;
  localparam int PAL_SIZE  = 96;
  localparam int PAL_IDX_W = 7;
  localparam int SEG_BITS  = 4;
  localparam logic [PAL_IDX_W-1:0] PAL_LAST = PAL_IDX_W'(PAL_SIZE - 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_MUL,
    ST_BOUND,
    ST_SUM,
    ST_DONE
  } mec_state_t;

  // which product the shared multiplier is working on
  typedef enum logic [1:0] {
    OP_XY,
    OP_XX,
    OP_YY
  } mul_op_t;

  // six hue segments of sixteen entries, one channel off, one full, one ramping down
  function automatic logic [COLOR_W-1:0] palette_color(input logic [PAL_IDX_W-1:0] idx);
    logic [7:0]                    ramp;
    logic [PAL_IDX_W-SEG_BITS-1:0] seg;
    logic [COLOR_W-1:0]            color;
    ramp = {~idx[SEG_BITS-1:0], 4'hf};
    seg  = idx[PAL_IDX_W-1:SEG_BITS];
    case (seg)
      3'd0:    color = {8'h00, 8'hff, ramp};
      3'd1:    color = {8'h00, ramp, 8'hff};
      3'd2:    color = {ramp, 8'h00, 8'hff};
      3'd3:    color = {8'hff, 8'h00, ramp};
      3'd4:    color = {ramp, 8'hff, 8'h00};
      3'd5:    color = {8'hff, ramp, 8'h00};
      default: color = '0;
    endcase
    return color;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mec_fxmul.sv @@
`default_nettype none

module mec_fxmul #(
  parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF,
  parameter int IW        = FRAC_BITS + 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [IW-1:0] a,
  input  wire logic signed [IW-1:0] b,
  output logic                      done,
  output logic signed [IW-1:0]      res
);
  import mec_pkg::*;

  // operand magnitudes stay below 2.0, split into two halves
  localparam int MW   = FRAC_BITS + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int PW   = 4 * H;
  localparam logic [2:0] LAST = 3'd5;
  localparam logic [2:0] NPP  = 3'd4;

  logic              busy_r, busy_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [2*H-1:0]    ma_r, ma_nxt, mb_r, mb_nxt;
  logic [2*H-1:0]    prod_r, prod_nxt;
  logic [1:0]        sh_r, sh_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic signed [IW-1:0] res_r, res_nxt;

  logic [IW-1:0]     a_mag, b_mag;
  logic [H-1:0]      a_part, b_part;
  logic [PW-1:0]     pp_aligned;
  logic signed [PW:0] sprod, sshift;

  // magnitudes of the operands
  assign a_mag = a[IW-1] ? IW'(-a) : IW'(a);
  assign b_mag = b[IW-1] ? IW'(-b) : IW'(b);

  // half selection for the current partial product
  assign a_part = step_r[0] ? ma_r[2*H-1:H] : ma_r[H-1:0];
  assign b_part = step_r[1] ? mb_r[2*H-1:H] : mb_r[H-1:0];

  // align the registered partial product
  always_comb begin
    case (sh_r)
      2'd0:    pp_aligned = PW'(prod_r);
      2'd1:    pp_aligned = PW'(prod_r) << H;
      default: pp_aligned = PW'(prod_r) << (2 * H);
    endcase
  end

  // signed exact product, floored to the fraction width
  assign sprod  = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign sshift = sprod >>> FRAC_BITS;

  // sequencing of the four partial products
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    prod_nxt = prod_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        neg_nxt  = a[IW-1] ^ b[IW-1];
        ma_nxt   = a_mag[2*H-1:0];
        mb_nxt   = b_mag[2*H-1:0];
        acc_nxt  = '0;
      end
    end else begin
      step_nxt = step_r + 3'd1;
      if (step_r < NPP) begin
        prod_nxt = a_part * b_part;
        sh_nxt   = 2'(step_r[0]) + 2'(step_r[1]);
      end
      if (step_r != '0 && step_r <= NPP) begin
        acc_nxt = acc_r + pp_aligned;
      end
      if (step_r == LAST) begin
        res_nxt  = sshift[IW-1:0];
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    prod_r <= prod_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

  // a new product is only requested while the unit is free
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");

  // the last step always hands out a result and frees the unit
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && step_r == LAST |=> done_r && !busy_r)
    else $error("multiplier did not finish after its last step");

endmodule

`default_nettype wire

@@ rtl/core/mandelbrot_escape_colorizer_top.sv @@
`default_nettype none

// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_point_real, in_point_imag
// out       output     out_valid/out_stall out_pixel_color, out_iteration_count, out_inside_set
// cfg       input      cfg_wr_en          cfg_wr_data (iteration limit)
//
// one point at a time: each iteration runs three products on the shared
// multiplier, plus bound, sum and loop steps.
// reset is synchronous, active low, and sets the limit to 4094.
// in_stall stays high from acceptance until the result transaction completes;
// the result is held while out_stall is high.

module mandelbrot_escape_colorizer_top #(
  parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [mec_pkg::POINT_W-1:0]  in_point_real,
  input  wire logic signed [mec_pkg::POINT_W-1:0]  in_point_imag,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [mec_pkg::COLOR_W-1:0]              out_pixel_color,
  output logic [mec_pkg::LIMIT_W-1:0]              out_iteration_count,
  output logic                                     out_inside_set,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mec_pkg::LIMIT_W-1:0]         cfg_wr_data
);
  import mec_pkg::*;

  // internal width covers magnitudes below 32 with the chosen fraction
  localparam int IW = FRAC_BITS + 6;
  localparam logic signed [IW-1:0] TWO =
    {{(IW-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [IW-1:0] NEG_TWO = -TWO;
  localparam logic signed [IW:0] FOUR =
    {{(IW-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

  mec_state_t           state_r, state_nxt;
  mul_op_t              op_r, op_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [LIMIT_W-1:0]   k_r, k_nxt;
  logic [PAL_IDX_W-1:0] idx_r, idx_nxt;
  logic signed [IW-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [IW-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [IW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, xx_r, xx_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic [LIMIT_W-1:0]   count_r, count_nxt;
  logic                 inside_r, inside_nxt;

  logic                 mul_start, mul_done;
  logic signed [IW-1:0] mul_a, mul_b, mul_res;
  logic signed [IW-1:0] cr_in, ci_in;
  logic signed [IW:0]   sq_sum;
  logic                 bound_hit;

  // input conversion to the internal fraction width
  if (FRAC_BITS >= IN_FRAC) begin : g_up
    logic signed [IW-1:0] r_ext, i_ext;
    assign r_ext = {{(IW-POINT_W){in_point_real[POINT_W-1]}}, in_point_real};
    assign i_ext = {{(IW-POINT_W){in_point_imag[POINT_W-1]}}, in_point_imag};
    assign cr_in = r_ext <<< (FRAC_BITS - IN_FRAC);
    assign ci_in = i_ext <<< (FRAC_BITS - IN_FRAC);
  end else begin : g_down
    logic signed [POINT_W-1:0] r_sh, i_sh;
    assign r_sh  = in_point_real >>> (IN_FRAC - FRAC_BITS);
    assign i_sh  = in_point_imag >>> (IN_FRAC - FRAC_BITS);
    assign cr_in = IW'(r_sh);
    assign ci_in = IW'(i_sh);
  end

  // shared fixed-point multiplier
  mec_fxmul #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // escape tests
  assign bound_hit = (wx_r >= TWO) || (wx_r <= NEG_TWO) ||
                     (wy_r >= TWO) || (wy_r <= NEG_TWO);
  assign sq_sum    = (IW+1)'(sx_r) + (IW+1)'(sy_r);

  // limit register, all ones clamps to the maximum
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr_en) begin
      limit_nxt = (cfg_wr_data == LIMIT_ALL_ONES) ? LIMIT_MAX : cfg_wr_data;
    end
  end

  // iteration sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    k_nxt      = k_r;
    idx_nxt    = idx_r;
    cr_nxt     = cr_r;
    ci_nxt     = ci_r;
    wx_nxt     = wx_r;
    wy_nxt     = wy_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    xx_nxt     = xx_r;
    color_nxt  = color_r;
    count_nxt  = count_r;
    inside_nxt = inside_r;
    mul_start  = 1'b0;
    mul_a      = wx_r;
    mul_b      = wy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cr_nxt    = cr_in;
          ci_nxt    = ci_in;
          wx_nxt    = '0;
          wy_nxt    = '0;
          sx_nxt    = '0;
          sy_nxt    = '0;
          k_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (k_r == limit_r) begin
          // never escaped within the limit
          color_nxt  = '0;
          count_nxt  = k_r + 1'b1;
          inside_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          idx_nxt   = (idx_r == PAL_LAST) ? '0 : idx_r + 1'b1;
          xx_nxt    = sx_r - sy_r;
          mul_start = 1'b1;
          op_nxt    = OP_XY;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          unique case (op_r)
            OP_XY: begin
              wy_nxt    = (mul_res <<< 1) + ci_r;
              wx_nxt    = xx_r + cr_r;
              state_nxt = ST_BOUND;
            end
            OP_XX: begin
              sx_nxt    = mul_res;
              mul_a     = wy_r;
              mul_b     = wy_r;
              mul_start = 1'b1;
              op_nxt    = OP_YY;
            end
            default: begin
              sy_nxt    = mul_res;
              state_nxt = ST_SUM;
            end
          endcase
        end
      end
      ST_BOUND: begin
        if (bound_hit) begin
          color_nxt  = palette_color(idx_r);
          count_nxt  = k_r;
          inside_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end else begin
          mul_a     = wx_r;
          mul_b     = wx_r;
          mul_start = 1'b1;
          op_nxt    = OP_XX;
          state_nxt = ST_MUL;
        end
      end
      ST_SUM: begin
        if (sq_sum >= FOUR) begin
          color_nxt  = palette_color(idx_r);
          count_nxt  = k_r;
          inside_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_ITER;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_XY;
      limit_r <= LIMIT_MAX;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      limit_r <= limit_nxt;
    end
  end

  // working values and result
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    idx_r    <= idx_nxt;
    cr_r     <= cr_nxt;
    ci_r     <= ci_nxt;
    wx_r     <= wx_nxt;
    wy_r     <= wy_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    xx_r     <= xx_nxt;
    color_r  <= color_nxt;
    count_r  <= count_nxt;
    inside_r <= inside_nxt;
  end

  // handshake and result ports
  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = (state_r == ST_DONE);
  assign out_pixel_color     = color_r;
  assign out_iteration_count = count_r;
  assign out_inside_set      = inside_r;

  // black exactly for points inside, every palette entry has a full channel
  a_black_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inside_set == (out_pixel_color == '0)))
    else $error("color does not match inside flag");

  // inside points report the limit plus one
  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_set |-> out_iteration_count == LIMIT_W'(limit_r + 1'b1))
    else $error("inside count is not limit plus one");

  // escaped points report a count between one and the limit
  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_set |->
      out_iteration_count != '0 && out_iteration_count <= limit_r)
    else $error("escape count out of range");

  // the limit never holds all ones, so the inside count cannot wrap
  a_limit_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r != LIMIT_ALL_ONES)
    else $error("iteration limit not clamped");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;
  import mec_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE_TICKS = 8;
  localparam int IDLE_PCT     = 11;

  // instance uses the default fraction width
  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam int     FRAC_SHIFT   = FRAC - IN_FRAC;
  localparam longint ESCAPE_BOUND = longint'(1) <<< (FRAC + 1);
  localparam longint RADIUS_SQ    = longint'(1) <<< (FRAC + 2);

  // Q4.28 points used by the directed rows and the random phases
  localparam logic [POINT_W-1:0] PT_ZERO             = 32'h0000_0000;
  localparam logic [POINT_W-1:0] PT_MAX              = 32'h7fff_ffff;
  localparam logic [POINT_W-1:0] PT_MIN              = 32'h8000_0000;
  localparam logic [POINT_W-1:0] PT_TWO              = 32'h2000_0000;
  localparam logic [POINT_W-1:0] PT_NEG_TWO          = 32'he000_0000;
  localparam logic [POINT_W-1:0] PT_UNDER_TWO        = 32'h1fff_ffff;
  localparam logic [POINT_W-1:0] PT_NEG_ONE          = 32'hf000_0000;
  localparam logic [POINT_W-1:0] PT_THREE_HALVES     = 32'h1800_0000;
  localparam logic [POINT_W-1:0] PT_NEG_THREE_HALVES = 32'he800_0000;
  localparam logic [POINT_W-1:0] PT_ROOT_TWO         = 32'h16a0_9e66;
  localparam logic [POINT_W-1:0] PT_NEAR_QUARTER     = 32'h0428_f5c3;
  localparam logic [POINT_W-1:0] PT_SEAHORSE         = 32'hf400_0000;
  localparam logic [POINT_W-1:0] PT_CUSP             = 32'h0400_0000;
  localparam logic [POINT_W-1:0] PT_REGION_LEFT      = 32'hdc00_0000;
  localparam logic [POINT_W-1:0] PT_REGION_BOTTOM    = 32'hec00_0000;

  localparam logic [7:0] CH_OFF  = 8'h00;
  localparam logic [7:0] CH_FULL = 8'hff;

  typedef enum logic {
    ROW_POINT,
    ROW_LIMIT
  } row_kind_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [LIMIT_W-1:0] count;
    logic               in_set;
  } pixel_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [POINT_W-1:0] re;
    logic [POINT_W-1:0] im;
    logic [LIMIT_W-1:0] limit;
    logic               typed;
    pixel_t             want;
  } stim_row_t;

  localparam pixel_t NO_PIXEL      = '0;
  localparam pixel_t ESC_FIRST     = '{24'h00ffef, 12'd1, 1'b0};
  localparam pixel_t INSIDE_AT_MAX = '{24'h000000, 12'd4095, 1'b1};
  localparam pixel_t INSIDE_AT_ONE = '{24'h000000, 12'd1, 1'b1};
  localparam pixel_t INSIDE_AT_TWO = '{24'h000000, 12'd2, 1'b1};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [POINT_W-1:0] in_point_real = '0;
  logic signed [POINT_W-1:0] in_point_imag = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic [LIMIT_W-1:0]        out_iteration_count;
  logic                      out_inside_set;
  logic                      cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]        cfg_wr_data = '0;

  // expected pixels in order of acceptance
  pixel_t             pending_pixels[$];
  pixel_t             oldest_pixel;
  pixel_t             seen_pixel;
  logic [LIMIT_W-1:0] limit_now = LIMIT_MAX;
  bit                 steady_flow = 1'b0;
  int                 cycle_count = 0;
  int                 mismatches = 0;
  int                 points_sent = 0;
  int                 limits_written = 0;
  int                 inside_seen = 0;
  int                 escaped_seen = 0;
  int                 deepest_escape = 0;

  stim_row_t directed_rows[22];

  mandelbrot_escape_colorizer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_point_real       (in_point_real),
    .in_point_imag       (in_point_imag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pixel_color     (out_pixel_color),
    .out_iteration_count (out_iteration_count),
    .out_inside_set      (out_inside_set),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // exact product floored to the internal fraction width
  function automatic longint fixed_mul(longint a, longint b);
    logic signed [127:0] full;
    full = a * b;
    return longint'(full >>> FRAC);
  endfunction

  // six hue segments of sixteen shades each
  function automatic logic [COLOR_W-1:0] hue_color(int unsigned idx);
    logic [7:0]  ramp;
    int unsigned seg;
    seg  = idx / 16;
    ramp = 8'(255 - 16 * (idx % 16));
    case (seg)
      0:       return {CH_OFF, CH_FULL, ramp};
      1:       return {CH_OFF, ramp, CH_FULL};
      2:       return {ramp, CH_OFF, CH_FULL};
      3:       return {CH_FULL, CH_OFF, ramp};
      4:       return {ramp, CH_FULL, CH_OFF};
      default: return {CH_FULL, ramp, CH_OFF};
    endcase
  endfunction

  // escape-time iteration of z = z*z + c from z = 0
  function automatic pixel_t predict_pixel(logic [POINT_W-1:0] re, logic [POINT_W-1:0] im,
                                           logic [LIMIT_W-1:0] lim);
    longint      cr;
    longint      ci;
    longint      wx;
    longint      wy;
    longint      sx;
    longint      sy;
    longint      diff;
    longint      prod_xy;
    int unsigned iters;
    logic        escaped;
    pixel_t      res;
    cr      = longint'($signed(re)) <<< FRAC_SHIFT;
    ci      = longint'($signed(im)) <<< FRAC_SHIFT;
    wx      = 0;
    wy      = 0;
    sx      = 0;
    sy      = 0;
    iters   = 0;
    escaped = 1'b0;
    while (!escaped && iters < lim) begin
      diff    = sx - sy;
      prod_xy = fixed_mul(wx, wy);
      iters++;
      wy = 2 * prod_xy + ci;
      wx = diff + cr;
      // coarse bound first keeps the squares in range
      if (wx >= ESCAPE_BOUND || wx <= -ESCAPE_BOUND ||
          wy >= ESCAPE_BOUND || wy <= -ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        sx      = fixed_mul(wx, wx);
        sy      = fixed_mul(wy, wy);
        escaped = (sx + sy >= RADIUS_SQ);
      end
    end
    if (escaped) begin
      res = '{hue_color(iters % PAL_SIZE), LIMIT_W'(iters), 1'b0};
    end else begin
      res = '{COLOR_W'(0), LIMIT_W'(iters + 1), 1'b1};
    end
    return res;
  endfunction

  // drop valid and hold off until every pixel has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = (value > LIMIT_MAX) ? LIMIT_MAX : value;
    limits_written++;
  endtask

  // one point transaction, with an occasional gap before it
  task automatic send_point(logic [POINT_W-1:0] re, logic [POINT_W-1:0] im, pixel_t want);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_point_real <= re;
    in_point_imag <= im;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(want);
    points_sent++;
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_pixel = '{out_pixel_color, out_iteration_count, out_inside_set};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none, got color %h count %0d inside %b",
                 $time, seen_pixel.color, seen_pixel.count, seen_pixel.in_set);
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (seen_pixel.color !== oldest_pixel.color) begin
          mismatches++;
          $display("%0t: pixel_color expected %h got %h",
                   $time, oldest_pixel.color, seen_pixel.color);
        end
        if (seen_pixel.count !== oldest_pixel.count) begin
          mismatches++;
          $display("%0t: iteration_count expected %0d got %0d",
                   $time, oldest_pixel.count, seen_pixel.count);
        end
        if (seen_pixel.in_set !== oldest_pixel.in_set) begin
          mismatches++;
          $display("%0t: inside_set expected %b got %b",
                   $time, oldest_pixel.in_set, seen_pixel.in_set);
        end
        if (oldest_pixel.in_set) begin
          inside_seen++;
        end else begin
          escaped_seen++;
          if (int'(oldest_pixel.count) > deepest_escape) begin
            deepest_escape = int'(oldest_pixel.count);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [POINT_W-1:0] re;
    logic [POINT_W-1:0] im;
    int                 pick;

    // reset limit, then zero limit, limit one, short limit, out-of-range limit
    directed_rows = '{
      '{ROW_POINT, PT_MAX,              PT_ZERO,             12'd0,    1'b1, ESC_FIRST},
      '{ROW_POINT, PT_MIN,              PT_MIN,              12'd0,    1'b1, ESC_FIRST},
      '{ROW_POINT, PT_ZERO,             PT_MAX,              12'd0,    1'b1, ESC_FIRST},
      '{ROW_POINT, PT_ZERO,             PT_ZERO,             12'd0,    1'b1, INSIDE_AT_MAX},
      '{ROW_LIMIT, PT_ZERO,             PT_ZERO,             12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_ZERO,             PT_ZERO,             12'd0,    1'b1, INSIDE_AT_ONE},
      '{ROW_POINT, PT_MAX,              PT_MAX,              12'd0,    1'b1, INSIDE_AT_ONE},
      '{ROW_LIMIT, PT_ZERO,             PT_ZERO,             12'd1,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_TWO,              PT_ZERO,             12'd0,    1'b1, ESC_FIRST},
      '{ROW_POINT, PT_ZERO,             PT_ZERO,             12'd0,    1'b1, INSIDE_AT_TWO},
      '{ROW_POINT, PT_UNDER_TWO,        PT_ZERO,             12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_NEG_TWO,          PT_ZERO,             12'd0,    1'b1, ESC_FIRST},
      '{ROW_POINT, PT_ZERO,             PT_NEG_TWO,          12'd0,    1'b1, ESC_FIRST},
      '{ROW_LIMIT, PT_ZERO,             PT_ZERO,             12'd2,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_UNDER_TWO,        PT_ZERO,             12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_THREE_HALVES,     PT_THREE_HALVES,     12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_ROOT_TWO,         PT_ROOT_TWO,         12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_NEG_THREE_HALVES, PT_NEG_THREE_HALVES, 12'd0,    1'b0, NO_PIXEL},
      '{ROW_LIMIT, PT_ZERO,             PT_ZERO,             12'hfff,  1'b0, NO_PIXEL},
      '{ROW_POINT, PT_NEG_ONE,          PT_ZERO,             12'd0,    1'b1, INSIDE_AT_MAX},
      '{ROW_POINT, PT_NEAR_QUARTER,     PT_ZERO,             12'd0,    1'b0, NO_PIXEL},
      '{ROW_POINT, PT_MAX,              PT_MIN,              12'd0,    1'b1, ESC_FIRST}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LIMIT) begin
        write_limit(directed_rows[i].limit);
      end else begin
        send_point(directed_rows[i].re, directed_rows[i].im,
                   directed_rows[i].typed ? directed_rows[i].want
                                          : predict_pixel(directed_rows[i].re,
                                                          directed_rows[i].im, limit_now));
      end
    end

    // random phases, each at its own limit; one phase runs without idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_limit(LIMIT_W'($urandom_range(2, 16)));
        1:       write_limit(LIMIT_W'($urandom_range(17, 64)));
        2:       write_limit(LIMIT_W'($urandom_range(96, 250)));
        3:       write_limit(LIMIT_W'($urandom_range(2, 40)));
        default: write_limit(LIMIT_W'($urandom_range(65, 128)));
      endcase
      steady_flow = (phase == 3);
      for (int n = 0; n < 24; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // the interesting part of the plane
          re = PT_REGION_LEFT + $urandom_range(0, 32'h3000_0000);
          im = PT_REGION_BOTTOM + $urandom_range(0, 32'h2800_0000);
        end else if (pick < 8) begin
          // close to the boundary, where escapes take long
          if ($urandom_range(0, 1)) begin
            re = PT_SEAHORSE + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            im = $urandom_range(0, 32'h0200_0000);
          end else begin
            re = PT_CUSP + $urandom_range(0, 32'h0100_0000);
            im = $urandom_range(0, 32'h0100_0000);
          end
          if ($urandom_range(0, 1)) im = -im;
        end else begin
          // anywhere in the input range
          re = $urandom();
          im = $urandom();
        end
        send_point(re, im, predict_pixel(re, im, limit_now));
      end
      steady_flow = 1'b0;
    end

    wait_idle();
    repeat (40) @(posedge clk);

    $display("ran %0d points under %0d limit settings: %0d inside, %0d escaped",
             points_sent, limits_written, inside_seen, escaped_seen);
    $display("deepest escape %0d", deepest_escape);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ mandelbrot_escape_colorizer_top.f @@
rtl/core/mec_pkg.sv
rtl/core/mec_fxmul.sv
rtl/core/mandelbrot_escape_colorizer_top.sv
test/testbench.sv
